FILE: design/dss_pkg.sv
// Shared types, codes and the sequencer program of the dominator set solver.
package dss_pkg;

	// Input commands
	localparam logic [1:0] CMD_CLEAR   = 2'd0;
	localparam logic [1:0] CMD_EDGE    = 2'd1;
	localparam logic [1:0] CMD_COMPUTE = 2'd2;

	// Configuration register indexes
	typedef logic [0:0] cfg_idx_t;
	localparam cfg_idx_t CFG_NUM_BLOCKS  = 1'd0;
	localparam cfg_idx_t CFG_ENTRY_BLOCK = 1'd1;

	localparam int MASK_W  = 32;
	localparam int BLOCK_W = 5;
	localparam int COUNT_W = 6;

	typedef logic [3:0] pc_t;

	// Program steps
	localparam pc_t S_IDLE = 4'd0;
	localparam pc_t S_INIT = 4'd1;
	localparam pc_t S_PASS = 4'd2;
	localparam pc_t S_BLK  = 4'd3;
	localparam pc_t S_OLD  = 4'd4;
	localparam pc_t S_RDP  = 4'd5;
	localparam pc_t S_ANDP = 4'd6;
	localparam pc_t S_WR   = 4'd7;
	localparam pc_t S_NEXT = 4'd8;
	localparam pc_t S_PEND = 4'd9;
	localparam pc_t S_ERD  = 4'd10;
	localparam pc_t S_EMIT = 4'd11;
	localparam pc_t S_DONE = 4'd12;

	typedef enum logic [1:0] {RD_NONE, RD_I, RD_P} rd_sel_t;
	typedef enum logic [1:0] {I_HOLD, I_INC, I_CLR} i_op_t;
	typedef enum logic [1:0] {ACC_HOLD, ACC_INIT, ACC_AND} acc_op_t;
	typedef enum logic [1:0] {REM_HOLD, REM_LOAD, REM_DROP} rem_op_t;
	typedef enum logic [1:0] {CHG_HOLD, CHG_CLR, CHG_UPD} chg_op_t;
	typedef enum logic {W_INIT, W_NEW} wsel_t;
	typedef enum logic [2:0] {
		C_NONE, C_ALWAYS, C_NOT_START, C_ENTRY, C_REM_ZERO, C_REM_NZ, C_I_MORE, C_CHG
	} cond_t;

	typedef struct packed {
		logic    ready;
		logic    we;
		wsel_t   wsel;
		rd_sel_t rd_sel;
		i_op_t   i_op;
		acc_op_t acc_op;
		rem_op_t rem_op;
		logic    old_ld;
		chg_op_t chg_op;
		logic    emit;
		logic    wait_out;
		cond_t   cond;
		pc_t     target;
	} ctl_t;

	typedef struct packed {
		logic start;
		logic is_entry;
		logic rem_zero;
		logic i_more;
		logic chg;
		logic out_busy;
	} sts_t;

	// Control store
	function automatic ctl_t ucode(input pc_t pc);
		ctl_t c;
		c = '0;
		unique case (pc)
			S_IDLE: begin
				c.ready = 1'b1; c.i_op = I_CLR;
				c.cond = C_NOT_START; c.target = S_IDLE;
			end
			S_INIT: begin
				c.we = 1'b1; c.wsel = W_INIT; c.i_op = I_INC;
				c.cond = C_I_MORE; c.target = S_INIT;
			end
			S_PASS: begin
				c.i_op = I_CLR; c.chg_op = CHG_CLR;
			end
			S_BLK: begin
				c.rd_sel = RD_I; c.rem_op = REM_LOAD; c.acc_op = ACC_INIT;
				c.cond = C_ENTRY; c.target = S_NEXT;
			end
			S_OLD: begin
				c.old_ld = 1'b1; c.cond = C_REM_ZERO; c.target = S_WR;
			end
			S_RDP: begin
				c.rd_sel = RD_P; c.rem_op = REM_DROP;
			end
			S_ANDP: begin
				c.acc_op = ACC_AND; c.cond = C_REM_NZ; c.target = S_RDP;
			end
			S_WR: begin
				c.we = 1'b1; c.wsel = W_NEW; c.chg_op = CHG_UPD;
			end
			S_NEXT: begin
				c.i_op = I_INC; c.cond = C_I_MORE; c.target = S_BLK;
			end
			S_PEND: begin
				c.i_op = I_CLR; c.cond = C_CHG; c.target = S_PASS;
			end
			S_ERD: begin
				c.rd_sel = RD_I;
			end
			S_EMIT: begin
				c.wait_out = 1'b1; c.emit = 1'b1; c.i_op = I_INC;
				c.cond = C_I_MORE; c.target = S_ERD;
			end
			S_DONE: begin
				c.cond = C_ALWAYS; c.target = S_IDLE;
			end
			default: begin
				c.cond = C_ALWAYS; c.target = S_IDLE;
			end
		endcase
		return c;
	endfunction

endpackage

FILE: design/dss_chan_if.sv
// Valid/ready channel interfaces for command items and dominator rows.
interface dss_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [4:0] pred_block;
	logic [4:0] succ_block;

	modport source (output valid, output cmd, output pred_block, output succ_block,
		input ready);
	modport sink (input valid, input cmd, input pred_block, input succ_block,
		output ready);
endinterface

interface dss_result_if;
	logic        valid;
	logic        ready;
	logic [4:0]  block_index;
	logic [31:0] dominator_mask;
	logic        last_row;

	modport source (output valid, output block_index, output dominator_mask,
		output last_row, input ready);
	modport sink (input valid, input block_index, input dominator_mask,
		input last_row, output ready);
endinterface

FILE: design/dss_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dss_ram #(
	parameter int W = 32,
	parameter int D = 32
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic                 re,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem [D];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

FILE: design/dss_seq.sv
// Step counter and control store; picks the next step from the jump condition.
module dss_seq (
	input  logic          clk,
	input  logic          arst_n,
	input  dss_pkg::sts_t sts,
	output dss_pkg::ctl_t ctl
);
	dss_pkg::pc_t pc_q;
	dss_pkg::pc_t pc_d;
	logic         take;

	assign ctl = dss_pkg::ucode(pc_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= dss_pkg::S_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

	always_comb begin
		unique case (ctl.cond)
			dss_pkg::C_NONE:      take = 1'b0;
			dss_pkg::C_ALWAYS:    take = 1'b1;
			dss_pkg::C_NOT_START: take = !sts.start;
			dss_pkg::C_ENTRY:     take = sts.is_entry;
			dss_pkg::C_REM_ZERO:  take = sts.rem_zero;
			dss_pkg::C_REM_NZ:    take = !sts.rem_zero;
			dss_pkg::C_I_MORE:    take = sts.i_more;
			dss_pkg::C_CHG:       take = sts.chg;
			default:              take = 1'b0;
		endcase
		// hold the step while the output register is still full
		priority if (ctl.wait_out && sts.out_busy) begin
			pc_d = pc_q;
		end else if (take) begin
			pc_d = ctl.target;
		end else begin
			pc_d = pc_q + 4'd1;
		end
	end
endmodule

FILE: design/dss_dp.sv
// Datapath: config, predecessor rows, dominator row RAM, accumulator and output register.
module dss_dp #(
	parameter int NB = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  dss_pkg::cfg_idx_t    cfg_index,
	input  logic [5:0]           cfg_data,
	dss_item_if.sink             item,
	dss_result_if.source         result,
	input  dss_pkg::ctl_t        ctl,
	output dss_pkg::sts_t        sts
);
	localparam int AW = $clog2(NB);

	logic [5:0]    nb_q;
	logic [4:0]    entry_q;
	logic [NB-1:0] pred_q [NB];
	logic [AW-1:0] i_q;
	logic [NB-1:0] rem_q;
	logic [31:0]   acc_q;
	logic [31:0]   old_q;
	logic          chg_q;
	logic          out_valid_q;
	logic [4:0]    out_block_q;
	logic [31:0]   out_mask_q;
	logic          out_last_q;

	logic [5:0]    n6;
	logic [AW-1:0] n_last;
	logic [31:0]   full;
	logic [NB-1:0] preds;
	logic [AW-1:0] p_idx;
	logic [31:0]   onehot_i;
	logic [31:0]   nd;
	logic [31:0]   wdata;
	logic [31:0]   rdata;
	logic [AW-1:0] raddr;
	logic          re;
	logic          go;
	logic          accept;
	logic          is_entry;
	logic          out_busy;

	always_comb begin
		priority if (nb_q == 6'd0) begin
			n6 = 6'd1;
		end else if (nb_q > 6'(NB)) begin
			n6 = 6'(NB);
		end else begin
			n6 = nb_q;
		end
		for (int k = 0; k < 32; k++) begin
			full[k] = 6'(k) < n6;
		end
	end

	assign n_last   = AW'(n6 - 6'd1);
	assign preds    = pred_q[i_q] & full[NB-1:0];
	assign onehot_i = 32'(1) << i_q;
	assign is_entry = 5'(i_q) == entry_q;
	assign nd       = acc_q | onehot_i;
	assign wdata    = (ctl.wsel == dss_pkg::W_NEW) ? nd : (is_entry ? onehot_i : full);

	// lowest pending predecessor
	always_comb begin
		p_idx = '0;
		for (int k = NB - 1; k >= 0; k--) begin
			if (rem_q[k]) p_idx = AW'(k);
		end
	end

	assign out_busy = out_valid_q && !result.ready;
	assign go       = !(ctl.wait_out && out_busy);
	assign accept   = item.valid && ctl.ready;
	assign raddr    = (ctl.rd_sel == dss_pkg::RD_P) ? p_idx : i_q;
	assign re       = go && (ctl.rd_sel != dss_pkg::RD_NONE);

	dss_ram #(.W(32), .D(NB)) u_dom (
		.clk   (clk),
		.we    (ctl.we),
		.waddr (i_q),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nb_q    <= 6'd1;
			entry_q <= 5'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dss_pkg::CFG_NUM_BLOCKS:  nb_q <= cfg_data;
				dss_pkg::CFG_ENTRY_BLOCK: entry_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < NB; r++) begin
				pred_q[r] <= '0;
			end
		end else if (accept) begin
			if (item.cmd == dss_pkg::CMD_CLEAR) begin
				for (int r = 0; r < NB; r++) begin
					pred_q[r] <= '0;
				end
			end else if (item.cmd == dss_pkg::CMD_EDGE && 6'(item.pred_block) < n6
					&& 6'(item.succ_block) < n6) begin
				pred_q[item.succ_block[AW-1:0]][item.pred_block[AW-1:0]] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q   <= '0;
			chg_q <= 1'b0;
		end else if (go) begin
			unique case (ctl.i_op)
				dss_pkg::I_INC: i_q <= i_q + AW'(1);
				dss_pkg::I_CLR: i_q <= '0;
				default: ;
			endcase
			unique case (ctl.chg_op)
				dss_pkg::CHG_CLR: chg_q <= 1'b0;
				dss_pkg::CHG_UPD: if (nd != old_q) chg_q <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctl.rem_op)
			dss_pkg::REM_LOAD: rem_q <= preds;
			dss_pkg::REM_DROP: rem_q <= rem_q & (rem_q - NB'(1));
			default: ;
		endcase
		unique case (ctl.acc_op)
			dss_pkg::ACC_INIT: acc_q <= (|preds) ? full : '0;
			dss_pkg::ACC_AND:  acc_q <= acc_q & rdata;
			default: ;
		endcase
		if (ctl.old_ld) begin
			old_q <= rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && ctl.emit) begin
			out_block_q <= 5'(i_q);
			out_mask_q  <= rdata;
			out_last_q  <= i_q == n_last;
		end
	end

	assign item.ready            = ctl.ready;
	assign result.valid          = out_valid_q;
	assign result.block_index    = out_block_q;
	assign result.dominator_mask = out_mask_q;
	assign result.last_row       = out_last_q;

	assign sts.start    = item.valid && item.cmd == dss_pkg::CMD_COMPUTE;
	assign sts.is_entry = is_entry;
	assign sts.rem_zero = rem_q == '0;
	assign sts.i_more   = i_q != n_last;
	assign sts.chg      = chg_q;
	assign sts.out_busy = out_busy;

`ifndef SYNTHESIS
	a_pred_pending: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.rd_sel == dss_pkg::RD_P |-> rem_q != '0)
		else $error("predecessor read with no pending predecessor");
	a_row_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.block_index <= 5'(n_last))
		else $error("result row beyond active block count");
	a_entry_fixed: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.we && ctl.wsel == dss_pkg::W_NEW |-> !is_entry)
		else $error("entry block row rewritten during a pass");
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.cmd == dss_pkg::CMD_COMPUTE |=> !item.ready)
		else $error("input still open after compute beat");
`endif
endmodule

FILE: design/dominator_set_solver.sv
// Dominator set solver: loads predecessor edges, then solves and streams
// dominator rows for every block.
//
// item channel: one beat per command. A compute beat closes the input until its
// last row sits in the output register; the input reopens once the sequencer
// has passed its done step after that row is loaded.
// result channel: one beat per block 0..n-1, last_row set on block n-1.
// Configuration (num_blocks, entry_block) is written through cfg_we/cfg_index/
// cfg_data; the user must only do so while nothing is in flight (not enforced).
// Compute: the rows are seeded, then passes run until a pass changes no row. A
// pass visits every block; the entry block keeps its row, every other block
// reads its old row, ANDs in each predecessor's row in turn and writes the new
// row back, since every row access uses the single read port of the dominator RAM.
// Emission reads each row, then loads it into the output register, which may
// still offer the previous row while the next is read. A stalled receiver
// holds the output register and the sequencer waits on it; nothing is dropped.
// Reset clears the graph, sets num_blocks to 1 and entry_block to 0, and leaves
// the block idle with its input open; no clearing sweep is needed.
module dominator_set_solver #(
	parameter int MAX_BLOCKS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  dss_pkg::cfg_idx_t cfg_index,
	input  logic [5:0]        cfg_data,
	dss_item_if.sink          item,
	dss_result_if.source      result
);
	localparam int NB = (MAX_BLOCKS < 32) ? MAX_BLOCKS : 32;

	dss_pkg::ctl_t ctl;
	dss_pkg::sts_t sts;

	dss_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.ctl    (ctl)
	);

	dss_dp #(.NB(NB)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item),
		.result    (result),
		.ctl       (ctl),
		.sts       (sts)
	);
endmodule
